// ===== sv/idfl_pkg.sv =====
`default_nettype none

package idfl_pkg;

	// Allocator sizing
	localparam int MAX_IDS = 1024;
	localparam int CHUNK   = 128;

	// Field widths
	localparam int IdW     = 10;
	localparam int CntW    = $clog2(MAX_IDS + 1);
	localparam int AddrW   = $clog2(MAX_IDS);
	localparam int StatusW = 2;
	localparam int InDataW = ((IdW + 7) / 8) * 8;
	localparam int OutDataW = ((IdW + 7) / 8) * 8;

	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [StatusW-1:0] {
		STATUS_OK     = 2'd0,
		STATUS_EMPTY  = 2'd1,
		STATUS_BADREL = 2'd2
	} status_t;

	// Core to store: reads issued at accept, writes issued at execute
	typedef struct packed {
		logic             rd_en;
		logic [AddrW-1:0] mark_raddr;
		logic [AddrW-1:0] link_raddr;
		logic             mark_we;
		logic [AddrW-1:0] mark_waddr;
		logic             mark_wdata;
		logic             link_we;
		logic [AddrW-1:0] link_waddr;
		logic [AddrW-1:0] link_wdata;
	} store_req_t;

	// Store to core: registered read data
	typedef struct packed {
		logic             mark;
		logic [AddrW-1:0] link;
	} store_rsp_t;

endpackage

`default_nettype wire

// ===== sv/id_free_list_allocator_unit.sv =====
// Channel   Dir  Bits            Contents
// s_        in   tdata[15:0]     release_id [9:0], zero [15:10]
//                tuser[0]        opcode (0 acquire, 1 release)
// m_        out  tdata[15:0]     granted_id [9:0], zero [15:10]
//                tuser[1:0]      status (0 ok, 1 none free, 2 bad release)
//
// Each request is accepted, which issues reads of the in-use mark and of
// the queue head's link, then executed, using the registered data to write back.
// A result sits in the output register while the next request is accepted;
// the execute step waits only if that register is still full.
// Reset clears control and pointers; no clearing pass, marks past the fresh
// pointer read as clear.
`default_nettype none

module id_free_list_allocator_unit
	import idfl_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [InDataW-1:0]  s_tdata,   // release_id
	input  wire logic [0:0]          s_tuser,   // opcode
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OutDataW-1:0]      m_tdata,   // granted_id
	output logic [StatusW-1:0]       m_tuser    // status
);

	store_req_t      st_req;
	store_rsp_t      st_rsp;
	logic [CntW-1:0] fill_cnt;
	logic            res_valid;
	logic            res_ready;
	logic [IdW-1:0]  res_id;
	status_t         res_status;
	op_t             req_op;

	logic            out_valid_q;
	logic [IdW-1:0]  out_id_q;
	status_t         out_status_q;

	assign req_op = op_t'(s_tuser[0]);

	idfl_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.req_op     (req_op),
		.req_id     (s_tdata[IdW-1:0]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_id     (res_id),
		.res_status (res_status),
		.st_req     (st_req),
		.st_rsp     (st_rsp),
		.fill_cnt   (fill_cnt)
	);

	idfl_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (st_req),
		.fill_cnt (fill_cnt),
		.rsp      (st_rsp)
	);

	// Output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_id_q     <= res_id;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OutDataW'(out_id_q);
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

// ===== sv/idfl_store.sv =====
`default_nettype none

module idfl_store
	import idfl_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire store_req_t     req,
	input  wire logic [CntW-1:0] fill_cnt,  // ids below this have a written mark
	output store_rsp_t          rsp
);

	logic             mark_mem [MAX_IDS];
	logic [AddrW-1:0] link_mem [MAX_IDS];

	logic             mark_rd_s1;
	logic             mark_ok_s1;
	logic [AddrW-1:0] link_rd_s1;

	// In-use marks: one write, one registered read
	always_ff @(posedge clk) begin
		if (req.mark_we) begin
			mark_mem[req.mark_waddr] <= req.mark_wdata;
		end
		if (req.rd_en) begin
			mark_rd_s1 <= mark_mem[req.mark_raddr];
		end
	end

	// Link store: one write, one registered read
	always_ff @(posedge clk) begin
		if (req.link_we) begin
			link_mem[req.link_waddr] <= req.link_wdata;
		end
		if (req.rd_en) begin
			link_rd_s1 <= link_mem[req.link_raddr];
		end
	end

	// Marks past the fill count were never written and read as clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_ok_s1 <= 1'b0;
		end else if (req.rd_en) begin
			mark_ok_s1 <= (int'(req.mark_raddr) < int'(fill_cnt));
		end
	end

	assign rsp.mark = mark_rd_s1 & mark_ok_s1;
	assign rsp.link = link_rd_s1;

endmodule

`default_nettype wire

// ===== sv/idfl_core.sv =====
`default_nettype none

module idfl_core
	import idfl_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	// request side
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire op_t             req_op,
	input  wire logic [IdW-1:0]  req_id,
	// result side
	output logic                 res_valid,
	input  wire logic            res_ready,
	output logic [IdW-1:0]       res_id,
	output status_t              res_status,
	// store
	output store_req_t           st_req,
	input  wire store_rsp_t      st_rsp,
	output logic [CntW-1:0]      fill_cnt
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	localparam logic [CntW:0] MaxIdsW = (CntW+1)'(MAX_IDS);

	state_t           state_q;
	op_t              op_q;
	logic [IdW-1:0]   rel_id_q;
	logic [CntW-1:0]  fresh_q;
	logic [CntW-1:0]  cap_q;
	logic [AddrW-1:0] head_q;
	logic [AddrW-1:0] tail_q;
	logic             nonempty_q;

	logic             accept;
	logic             exec;
	logic [CntW:0]    want_w;
	logic [CntW-1:0]  grown_cap;
	logic             fresh_avail;
	logic             rel_ok;
	logic [AddrW-1:0] rel_addr;

	logic [CntW-1:0]  fresh_d;
	logic [CntW-1:0]  cap_d;
	logic [AddrW-1:0] head_d;
	logic [AddrW-1:0] tail_d;
	logic             nonempty_d;
	logic [AddrW-1:0] grant_addr;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign exec      = (state_q == S_EXEC) && res_ready;
	assign res_valid = exec;
	assign fill_cnt  = fresh_q;

	// Next capacity step: next multiple of the chunk, clamped to the cap
	assign want_w    = (CntW+1)'(((int'(cap_q) / CHUNK) + 1) * CHUNK);
	assign grown_cap = (want_w > MaxIdsW) ? CntW'(MAX_IDS) : want_w[CntW-1:0];

	assign fresh_avail = (fresh_q < cap_q);
	assign rel_addr    = AddrW'(rel_id_q);
	assign rel_ok      = (int'(rel_id_q) < int'(cap_q)) && st_rsp.mark;

	// Execute: decide the result and the state update
	always_comb begin
		fresh_d    = fresh_q;
		cap_d      = cap_q;
		head_d     = head_q;
		tail_d     = tail_q;
		nonempty_d = nonempty_q;
		grant_addr = '0;
		res_id     = '0;
		res_status = STATUS_OK;

		st_req            = '0;
		st_req.rd_en      = accept;
		st_req.mark_raddr = AddrW'(req_id);
		st_req.link_raddr = head_q;

		if (op_q == OP_ACQUIRE) begin
			if (!fresh_avail && !nonempty_q && (cap_q >= CntW'(MAX_IDS))) begin
				res_status = STATUS_EMPTY;
			end else begin
				if (!fresh_avail && !nonempty_q) begin
					// grow: fresh range starts at the old capacity
					grant_addr = AddrW'(cap_q);
					fresh_d    = cap_q + 1'b1;
					cap_d      = grown_cap;
				end else if (fresh_avail) begin
					grant_addr = AddrW'(fresh_q);
					fresh_d    = fresh_q + 1'b1;
				end else begin
					// pop the released queue
					grant_addr = head_q;
					if (head_q == tail_q) begin
						nonempty_d = 1'b0;
					end else begin
						head_d = st_rsp.link;
					end
				end
				res_id            = IdW'(grant_addr);
				st_req.mark_we    = exec;
				st_req.mark_waddr = grant_addr;
				st_req.mark_wdata = 1'b1;
			end
		end else begin
			if (!rel_ok) begin
				res_status = STATUS_BADREL;
			end else begin
				st_req.mark_we    = exec;
				st_req.mark_waddr = rel_addr;
				st_req.mark_wdata = 1'b0;
				if (nonempty_q) begin
					st_req.link_we    = exec;
					st_req.link_waddr = tail_q;
					st_req.link_wdata = rel_addr;
				end else begin
					head_d = rel_addr;
				end
				tail_d     = rel_addr;
				nonempty_d = 1'b1;
			end
		end
	end

	// Sequencer and allocator registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_ACQUIRE;
			rel_id_q   <= '0;
			fresh_q    <= '0;
			cap_q      <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			nonempty_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= req_op;
						rel_id_q <= req_id;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec) begin
						fresh_q    <= fresh_d;
						cap_q      <= cap_d;
						head_q     <= head_d;
						tail_q     <= tail_d;
						nonempty_q <= nonempty_d;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Fresh range never runs past capacity
	a_fresh_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= cap_q)
		else $error("fresh pointer beyond capacity");

	// Capacity never exceeds the cap
	a_cap_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q <= CntW'(MAX_IDS))
		else $error("capacity beyond maximum");

	// Capacity only moves on an acquire that found nothing free
	a_cap_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q != $past(cap_q)) |->
		($past(exec) && ($past(op_q) == OP_ACQUIRE) && !$past(nonempty_q)))
		else $error("capacity changed outside a grow");

	// Memory writes happen only in the execute step
	a_write_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(st_req.mark_we || st_req.link_we) |-> exec)
		else $error("store write outside execute");

	// No new request is accepted while one is executing
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !accept)
		else $error("request accepted while executing");

endmodule

`default_nettype wire

// ===== tb/sv/id_free_list_allocator_unit_test.sv =====
`default_nettype none

module id_free_list_allocator_unit_test;
	import idfl_pkg::*;

	localparam int CycleLimit = 250000;
	localparam int HoldCycles = 300;

	typedef struct {
		logic [IdW-1:0] gid;
		status_t        st;
	} reply_t;

	typedef struct {
		op_t            op;
		logic [IdW-1:0] rid;
		bit             known;
		logic [IdW-1:0] gid;
		status_t        st;
	} step_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;   // release_id [9:0], zero above
	logic [0:0]          s_tuser = '0;   // opcode
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;        // granted_id [9:0], zero above
	logic [StatusW-1:0]  m_tuser;        // status

	id_free_list_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// Allocator shadow state
	logic [AddrW-1:0] next_link [MAX_IDS];
	bit               id_busy [MAX_IDS];
	logic [CntW-1:0]  fresh_ptr;
	logic [CntW-1:0]  capacity;
	logic [AddrW-1:0] queue_head;
	logic [AddrW-1:0] queue_tail;
	bit               queue_full;

	reply_t          pending_replies[$];
	logic [IdW-1:0]  held_ids[$];
	int              errors = 0;
	int              cycle_count = 0;
	int              exhausted_seen = 0;
	bit              steady = 1'b0;
	bit              hold_req = 1'b0;
	int              hold_left = 0;

	// Work out the reply of one request and advance the shadow state
	function automatic reply_t alloc_step(input op_t op, input logic [IdW-1:0] rid);
		reply_t r;
		int     want;
		int     id;
		r.gid = '0;
		r.st  = STATUS_OK;
		if (op == OP_ACQUIRE) begin
			if (fresh_ptr >= capacity && !queue_full) begin
				if (capacity >= MAX_IDS) begin
					r.st = STATUS_EMPTY;
					return r;
				end
				want = ((int'(capacity) + CHUNK) / CHUNK) * CHUNK;
				if (want > MAX_IDS)
					want = MAX_IDS;
				fresh_ptr = capacity;
				capacity  = CntW'(want);
			end
			if (fresh_ptr < capacity) begin
				id = fresh_ptr;
				fresh_ptr = fresh_ptr + 1'b1;
			end else begin
				id = queue_head;
				if (queue_head == queue_tail)
					queue_full = 1'b0;
				else
					queue_head = next_link[queue_head];
			end
			id_busy[id % MAX_IDS] = 1'b1;
			r.gid = IdW'(id);
		end else begin
			if (rid >= capacity || rid >= MAX_IDS || !id_busy[rid]) begin
				r.st = STATUS_BADREL;
				return r;
			end
			id_busy[rid] = 1'b0;
			if (queue_full)
				next_link[queue_tail] = rid;
			else
				queue_head = rid;
			queue_tail = rid;
			queue_full = 1'b1;
		end
		return r;
	endfunction

	// Offer one request, wait for the handshake, record what must come back
	task automatic offer(input op_t op, input logic [IdW-1:0] rid, input bit known,
			input logic [IdW-1:0] kgid, input status_t kst);
		reply_t r;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= InDataW'(rid);
		do @(posedge clk); while (!s_tready);
		r = alloc_step(op, rid);
		if (r.st == STATUS_EMPTY)
			exhausted_seen++;
		if (r.st == STATUS_OK && op == OP_ACQUIRE)
			held_ids.push_back(r.gid);
		if (r.st == STATUS_OK && op == OP_RELEASE) begin
			foreach (held_ids[i])
				if (held_ids[i] == rid) begin
					held_ids.delete(i);
					break;
				end
		end
		if (known) begin
			r.gid = kgid;
			r.st  = kst;
		end
		pending_replies.push_back(r);
	endtask

	// Random sender gap after an accepted request
	task automatic sender_gap();
		if (!steady && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stop offering until every reply is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	// One random request; releases mostly return an identifier held right now
	task automatic random_request(input int acq_pct);
		logic [IdW-1:0] rid;
		rid = IdW'($urandom_range(1023));
		if ($urandom_range(99) < acq_pct) begin
			offer(OP_ACQUIRE, rid, 1'b0, '0, STATUS_OK);
		end else begin
			if (held_ids.size() != 0 && $urandom_range(99) < 85)
				rid = held_ids[$urandom_range(held_ids.size() - 1)];
			offer(OP_RELEASE, rid, 1'b0, '0, STATUS_OK);
		end
		sender_gap();
	endtask

	// Receiver: random back-pressure, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
		end
	end

	// Reply checker
	always @(posedge clk) begin
		reply_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected reply: granted_id %0d status %0d", m_tdata, m_tuser);
				errors++;
			end else begin
				e = pending_replies.pop_front();
				if (m_tdata !== OutDataW'(e.gid)) begin
					$error("granted_id: expected %0d, actual %0d", e.gid, m_tdata);
					errors++;
				end
				if (m_tuser !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Watchdog
	initial begin
		while (cycle_count < CycleLimit)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		step_row_t table_rows[17];
		int        sent;
		int        tail_items;

		table_rows = '{
			'{OP_RELEASE, 10'd0,    1'b1, 10'd0, STATUS_BADREL}, // nothing allocated yet
			'{OP_ACQUIRE, 10'd0,    1'b1, 10'd0, STATUS_OK},     // first growth
			'{OP_ACQUIRE, 10'h3FF,  1'b1, 10'd1, STATUS_OK},
			'{OP_RELEASE, 10'd1023, 1'b1, 10'd0, STATUS_BADREL}, // beyond capacity
			'{OP_RELEASE, 10'd127,  1'b1, 10'd0, STATUS_BADREL}, // never granted
			'{OP_RELEASE, 10'd1,    1'b1, 10'd0, STATUS_OK},
			'{OP_RELEASE, 10'd1,    1'b1, 10'd0, STATUS_BADREL}, // double release
			'{OP_ACQUIRE, 10'd0,    1'b1, 10'd2, STATUS_OK},     // fresh ahead of freed
			'{OP_RELEASE, 10'd0,    1'b1, 10'd0, STATUS_OK},
			'{OP_RELEASE, 10'd2,    1'b1, 10'd0, STATUS_OK},
			'{OP_ACQUIRE, 10'd0,    1'b0, 10'd0, STATUS_OK},
			'{OP_RELEASE, 10'd3,    1'b0, 10'd0, STATUS_OK},
			'{OP_RELEASE, 10'd128,  1'b1, 10'd0, STATUS_BADREL}, // just past capacity
			'{OP_ACQUIRE, 10'd0,    1'b0, 10'd0, STATUS_OK},
			'{OP_RELEASE, 10'h2AA,  1'b1, 10'd0, STATUS_BADREL},
			'{OP_RELEASE, 10'h155,  1'b1, 10'd0, STATUS_BADREL},
			'{OP_ACQUIRE, 10'd0,    1'b0, 10'd0, STATUS_OK}
		};

		// Shadow state after reset; links start at zero but are never read unwritten
		foreach (next_link[i]) begin
			next_link[i] = '0;
			id_busy[i]   = 1'b0;
		end
		fresh_ptr  = '0;
		capacity   = '0;
		queue_head = '0;
		queue_tail = '0;
		queue_full = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows
		foreach (table_rows[i]) begin
			offer(table_rows[i].op, table_rows[i].rid, table_rows[i].known,
				table_rows[i].gid, table_rows[i].st);
			sender_gap();
		end
		drain();

		// Balanced mix, with a stretch of no idling on either side
		sent = 0;
		repeat (350) begin
			steady = (sent >= 100 && sent < 250);
			random_request(50);
			sent++;
		end
		steady = 1'b0;
		drain();

		// Acquire-heavy run up to the cap and into exhaustion, under a long hold-off
		hold_req = 1'b1;
		while (exhausted_seen < 6) begin
			random_request(97);
			sent++;
		end
		drain();

		// Give identifiers back, then a mix again
		tail_items = (1830 - sent > 200) ? 1830 - sent : 200;
		for (int i = 0; i < tail_items; i++)
			random_request(i < tail_items / 2 ? 30 : 50);

		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
